/* hdl/mvsf_pkg.sv */
// Shared types and constants for the memory value search filter.
// No dependencies; used by mvsf_compare and memory_value_search_filter_core.
package mvsf_pkg;

    localparam int ADDR_W      = 21;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 22;
    localparam int MODE_W      = 4;
    localparam int WIDTH_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    // Wide enough to hold the largest address space size
    localparam int ADDR_CMP_W  = 25;

    localparam int ADDRESS_SPACE_BYTES_DEFAULT = 32'h0020_0000;

    typedef enum logic [MODE_W-1:0] {
        CMP_EQ    = 4'd0,
        CMP_NE    = 4'd1,
        CMP_RANGE = 4'd2,
        CMP_INCBY = 4'd3,
        CMP_DECBY = 4'd4,
        CMP_INC   = 4'd5,
        CMP_DEC   = 4'd6,
        CMP_DIFF  = 4'd7,
        CMP_SAME  = 4'd8
    } cmp_mode_t;

    typedef enum logic [WIDTH_W-1:0] {
        WIDTH_BYTE = 2'd0,
        WIDTH_HALF = 2'd1,
        WIDTH_WORD = 2'd2
    } width_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COMPARE_MODE = 2'd0,
        CFG_VALUE_WIDTH  = 2'd1,
        CFG_MATCH_VALUE  = 2'd2,
        CFG_UPPER_BOUND  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0]  compare_mode;
        logic [WIDTH_W-1:0] value_width;
        logic [VALUE_W-1:0] match_value;
        logic [VALUE_W-1:0] upper_bound;
    } cfg_t;

endpackage

/* hdl/mvsf_compare.sv */
// Value compare for one candidate: width masking and the nine compare modes.
// Depends on mvsf_pkg.
module mvsf_compare
(
    input  mvsf_pkg::cfg_t                 cfg,
    input  logic [mvsf_pkg::VALUE_W-1:0]   current_value,
    input  logic [mvsf_pkg::VALUE_W-1:0]   previous_value,
    output logic                           pass
);

    logic [mvsf_pkg::VALUE_W-1:0] mask;
    logic                         wide;
    logic [mvsf_pkg::VALUE_W-1:0] cur_m;
    logic [mvsf_pkg::VALUE_W-1:0] prev_m;
    logic [mvsf_pkg::VALUE_W-1:0] val_m;
    logic [mvsf_pkg::VALUE_W-1:0] hi_m;
    logic [mvsf_pkg::VALUE_W:0]   up_diff;
    logic [mvsf_pkg::VALUE_W:0]   down_diff;

    always_comb
    begin
        unique case (cfg.value_width)
            mvsf_pkg::WIDTH_BYTE:
            begin
                mask = mvsf_pkg::VALUE_W'(8'hFF);
                wide = 1'b0;
            end
            mvsf_pkg::WIDTH_HALF:
            begin
                mask = mvsf_pkg::VALUE_W'(16'hFFFF);
                wide = 1'b0;
            end
            default:
            begin
                // word, and the unused code behaves as word
                mask = '1;
                wide = 1'b1;
            end
        endcase
    end

    assign cur_m  = current_value & mask;
    assign prev_m = previous_value & mask;
    assign val_m  = cfg.match_value & mask;
    assign hi_m   = cfg.upper_bound & mask;

    // top bit is the borrow; narrow widths must not wrap
    assign up_diff   = {1'b0, cur_m} - {1'b0, prev_m};
    assign down_diff = {1'b0, prev_m} - {1'b0, cur_m};

    always_comb
    begin
        unique case (cfg.compare_mode)
            mvsf_pkg::CMP_EQ:    pass = (cur_m == val_m);
            mvsf_pkg::CMP_NE:    pass = (cur_m != val_m);
            mvsf_pkg::CMP_RANGE: pass = (cur_m >= val_m) && (cur_m <= hi_m);
            mvsf_pkg::CMP_INCBY: pass = (wide || !up_diff[mvsf_pkg::VALUE_W])
                                        && (up_diff[mvsf_pkg::VALUE_W-1:0] == val_m);
            mvsf_pkg::CMP_DECBY: pass = (wide || !down_diff[mvsf_pkg::VALUE_W])
                                        && (down_diff[mvsf_pkg::VALUE_W-1:0] == val_m);
            mvsf_pkg::CMP_INC:   pass = (prev_m < cur_m);
            mvsf_pkg::CMP_DEC:   pass = (prev_m > cur_m);
            mvsf_pkg::CMP_DIFF:  pass = (prev_m != cur_m);
            mvsf_pkg::CMP_SAME:  pass = (prev_m == cur_m);
            default:             pass = 1'b0;
        endcase
    end

endmodule

/* hdl/memory_value_search_filter_core.sv */
// Memory value search filter: input register, compare, result register.
// An accepted item is registered in the input register, then in the result register.
// Throughput: one item per cycle unless stalled; in_stall rises only when both the input
// register and the result register hold items and out_stall is high.
// Reset clears the configuration registers, the kept counter and both valids.
// Depends on mvsf_pkg and mvsf_compare.
module memory_value_search_filter_core
#(
    parameter int ADDRESS_SPACE_BYTES = mvsf_pkg::ADDRESS_SPACE_BYTES_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write,
    input  logic [mvsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mvsf_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mvsf_pkg::ADDR_W-1:0]       address,
    input  logic [mvsf_pkg::VALUE_W-1:0]      current_value,
    input  logic [mvsf_pkg::VALUE_W-1:0]      previous_value,
    input  logic                              last_candidate,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              keep,
    output logic [mvsf_pkg::ADDR_W-1:0]       kept_address,
    output logic [mvsf_pkg::COUNT_W-1:0]      kept_count,
    output logic                              pass_done
);

    localparam int COUNT_MAX = (1 << mvsf_pkg::COUNT_W) - 1;
    localparam logic [mvsf_pkg::COUNT_W-1:0] COUNT_LIMIT =
        mvsf_pkg::COUNT_W'((ADDRESS_SPACE_BYTES < COUNT_MAX) ? ADDRESS_SPACE_BYTES : COUNT_MAX);
    localparam logic [mvsf_pkg::ADDR_CMP_W-1:0] ADDR_LIMIT =
        mvsf_pkg::ADDR_CMP_W'(ADDRESS_SPACE_BYTES);

    mvsf_pkg::cfg_t cfg_reg;

    logic                          s1_valid_reg;
    logic [mvsf_pkg::ADDR_W-1:0]   s1_address_reg;
    logic [mvsf_pkg::VALUE_W-1:0]  s1_current_reg;
    logic [mvsf_pkg::VALUE_W-1:0]  s1_previous_reg;
    logic                          s1_last_reg;

    logic                          out_valid_reg;
    logic                          keep_reg;
    logic [mvsf_pkg::ADDR_W-1:0]   kept_address_reg;
    logic [mvsf_pkg::COUNT_W-1:0]  kept_count_reg;
    logic                          pass_done_reg;

    logic [mvsf_pkg::COUNT_W-1:0]  count_reg;
    logic [mvsf_pkg::COUNT_W-1:0]  count_next;
    logic [mvsf_pkg::COUNT_W-1:0]  count_bumped;

    logic in_take;
    logic s1_move;
    logic cmp_pass;
    logic addr_ok;
    logic keep_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mvsf_pkg::CFG_COMPARE_MODE:
                    cfg_reg.compare_mode <= cfg_data[mvsf_pkg::MODE_W-1:0];
                mvsf_pkg::CFG_VALUE_WIDTH:
                    cfg_reg.value_width  <= cfg_data[mvsf_pkg::WIDTH_W-1:0];
                mvsf_pkg::CFG_MATCH_VALUE:
                    cfg_reg.match_value  <= cfg_data[mvsf_pkg::VALUE_W-1:0];
                mvsf_pkg::CFG_UPPER_BOUND:
                    cfg_reg.upper_bound  <= cfg_data[mvsf_pkg::VALUE_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // pipeline flow: stage 1 moves when the result register is free or drains
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_address_reg  <= address;
            s1_current_reg  <= current_value;
            s1_previous_reg <= previous_value;
            s1_last_reg     <= last_candidate;
        end
    end

    mvsf_compare u_compare
    (
        .cfg            (cfg_reg),
        .current_value  (s1_current_reg),
        .previous_value (s1_previous_reg),
        .pass           (cmp_pass)
    );

    assign addr_ok   = (mvsf_pkg::ADDR_CMP_W'(s1_address_reg) < ADDR_LIMIT);
    assign keep_next = addr_ok && cmp_pass;

    // saturating kept counter; cleared after the last item of a pass
    assign count_bumped = (keep_next && (count_reg < COUNT_LIMIT))
                          ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (s1_move)
            count_next = s1_last_reg ? '0 : count_bumped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            keep_reg         <= keep_next;
            kept_address_reg <= s1_address_reg;
            kept_count_reg   <= count_bumped;
            pass_done_reg    <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign keep         = keep_reg;
    assign kept_address = kept_address_reg;
    assign kept_count   = kept_count_reg;
    assign pass_done    = pass_done_reg;

    // checks
    a_keep_in_space: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && keep) |-> (mvsf_pkg::ADDR_CMP_W'(kept_address) < ADDR_LIMIT))
        else $error("kept item outside address space");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_last_reg) |=> (count_reg == '0))
        else $error("kept counter not cleared after last item");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= COUNT_LIMIT))
        else $error("kept counter above limit");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !s1_last_reg) |=> ((count_reg == $past(count_reg))
                                    || (count_reg == $past(count_reg) + 1'b1)))
        else $error("kept counter stepped by more than one");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while pipeline can move");

endmodule

/* tb/memory_value_search_filter_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for memory_value_search_filter_core: a clocked driver and monitor
// with a behavioral filter predictor; directed corner cases, then randomized search passes.
// Depends on mvsf_pkg and the core RTL.
module memory_value_search_filter_core_tb;
    import mvsf_pkg::*;

    localparam int SCAN_ITEMS = 1100;
    localparam int LONG_HOLD  = 300;
    localparam int SURVIVOR_LIMIT = (ADDRESS_SPACE_BYTES_DEFAULT < 4194303) ?
                                    ADDRESS_SPACE_BYTES_DEFAULT : 4194303;

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] cur;
        logic [VALUE_W-1:0] prev;
        logic               is_last;
        int                 gap;
    } candidate_t;

    typedef struct {
        logic               keep;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               done;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_COMPARE_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ADDR_W-1:0]      address = '0;
    logic [VALUE_W-1:0]     current_value = '0;
    logic [VALUE_W-1:0]     previous_value = '0;
    logic                   last_candidate = 1'b0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   keep;
    logic [ADDR_W-1:0]      kept_address;
    logic [COUNT_W-1:0]     kept_count;
    logic                   pass_done;

    memory_value_search_filter_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .address        (address),
        .current_value  (current_value),
        .previous_value (previous_value),
        .last_candidate (last_candidate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .keep           (keep),
        .kept_address   (kept_address),
        .kept_count     (kept_count),
        .pass_done      (pass_done)
    );

    // Shadow of the filter settings and the pass counter
    logic [MODE_W-1:0]  mode_setting = CMP_EQ;
    logic [WIDTH_W-1:0] width_setting = WIDTH_BYTE;
    logic [VALUE_W-1:0] match_setting = '0;
    logic [VALUE_W-1:0] upper_setting = '0;
    logic [COUNT_W-1:0] pass_survivors = '0;

    candidate_t candidate_queue[$];
    verdict_t   predicted_verdicts[$];

    int sender_idle_max = 0;
    int receiver_idle_max = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int idle_count = 0;
    int stall_left = 0;
    int error_count = 0;
    int candidates_sent = 0;
    int results_checked = 0;
    int kept_total = 0;
    int passes_closed = 0;
    int input_stall_cycles = 0;
    int items_made = 0;
    candidate_t outgoing;
    verdict_t   arrived;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] width_mask();
        case (width_setting)
            WIDTH_BYTE: return 32'h0000_00FF;
            WIDTH_HALF: return 32'h0000_FFFF;
            default:    return 32'hFFFF_FFFF;  // code 3 behaves as word
        endcase
    endfunction

    function automatic logic value_passes(logic [VALUE_W-1:0] cur_raw,
                                          logic [VALUE_W-1:0] prev_raw);
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] c;
        logic [VALUE_W-1:0] p;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] up_diff;
        logic [VALUE_W-1:0] down_diff;
        logic               wide;
        m = width_mask();
        wide = (m == 32'hFFFF_FFFF);
        c = cur_raw & m;
        p = prev_raw & m;
        v = match_setting & m;
        hi = upper_setting & m;
        up_diff = c - p;
        down_diff = p - c;
        case (mode_setting)
            CMP_EQ:    return c == v;
            CMP_NE:    return c != v;
            CMP_RANGE: return (c >= v) && (c <= hi);
            // narrow widths: a change the other way never counts
            CMP_INCBY: return (wide || c >= p) && (up_diff == v);
            CMP_DECBY: return (wide || p >= c) && (down_diff == v);
            CMP_INC:   return p < c;
            CMP_DEC:   return p > c;
            CMP_DIFF:  return p != c;
            CMP_SAME:  return p == c;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic verdict_t filter_candidate(logic [ADDR_W-1:0] addr,
                                                  logic [VALUE_W-1:0] cur,
                                                  logic [VALUE_W-1:0] prev,
                                                  logic is_last);
        verdict_t v;
        v.keep = (32'(addr) < ADDRESS_SPACE_BYTES_DEFAULT) && value_passes(cur, prev);
        if (v.keep && pass_survivors < SURVIVOR_LIMIT)
            pass_survivors = pass_survivors + 1'b1;
        v.addr = addr;
        v.count = pass_survivors;
        v.done = is_last;
        if (is_last)
            pass_survivors = '0;
        return v;
    endfunction

    // Sender: presents queued items, honoring the per-item idle gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            idle_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted_verdicts.push_back(filter_candidate(address, current_value,
                                                              previous_value, last_candidate));
                candidates_sent++;
            end
            if (in_valid && in_stall)
                input_stall_cycles++;
            if (!in_valid || !in_stall)
            begin
                if (candidate_queue.size() > 0 && idle_count >= candidate_queue[0].gap)
                begin
                    outgoing = candidate_queue.pop_front();
                    address <= outgoing.addr;
                    current_value <= outgoing.cur;
                    previous_value <= outgoing.prev;
                    last_candidate <= outgoing.is_last;
                    in_valid <= 1'b1;
                    idle_count = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (candidate_queue.size() > 0)
                        idle_count++;
                end
            end
        end
    end

    // Receiver: checks each result, then stalls for a drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (keep)
                    kept_total++;
                if (pass_done)
                    passes_closed++;
                if (predicted_verdicts.size() == 0)
                begin
                    $error("result with nothing pending: address %h", kept_address);
                    error_count++;
                end
                else
                begin
                    arrived = predicted_verdicts.pop_front();
                    if (keep !== arrived.keep)
                    begin
                        $error("keep: expected %0d, got %0d", arrived.keep, keep);
                        error_count++;
                    end
                    if (kept_address !== arrived.addr)
                    begin
                        $error("kept_address: expected %h, got %h", arrived.addr, kept_address);
                        error_count++;
                    end
                    if (kept_count !== arrived.count)
                    begin
                        $error("kept_count: expected %0d, got %0d", arrived.count, kept_count);
                        error_count++;
                    end
                    if (pass_done !== arrived.done)
                    begin
                        $error("pass_done: expected %0d, got %0d", arrived.done, pass_done);
                        error_count++;
                    end
                end
                stall_left = $urandom_range(0, receiver_idle_max);
            end
            if (holds_served != hold_requests)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (candidate_queue.size() != 0 || in_valid || predicted_verdicts.size() != 0);
    endtask

    // Writes all four registers; upper data bits of the narrow ones are junk on purpose
    task automatic apply_settings(logic [MODE_W-1:0] mode, logic [WIDTH_W-1:0] width,
                                  logic [VALUE_W-1:0] match, logic [VALUE_W-1:0] upper);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_COMPARE_MODE;
        cfg_data <= ($urandom & ~32'hF) | 32'(mode);
        @(posedge clk);
        cfg_index <= CFG_VALUE_WIDTH;
        cfg_data <= ($urandom & ~32'h3) | 32'(width);
        @(posedge clk);
        cfg_index <= CFG_MATCH_VALUE;
        cfg_data <= match;
        @(posedge clk);
        cfg_index <= CFG_UPPER_BOUND;
        cfg_data <= upper;
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_setting = mode;
        width_setting = width;
        match_setting = match;
        upper_setting = upper;
        @(negedge clk);
    endtask

    task automatic directed_case(logic [MODE_W-1:0] mode, logic [WIDTH_W-1:0] width,
                                 logic [VALUE_W-1:0] match, logic [VALUE_W-1:0] upper,
                                 logic [ADDR_W-1:0] addr, logic [VALUE_W-1:0] cur,
                                 logic [VALUE_W-1:0] prev, logic is_last);
        candidate_t c;
        apply_settings(mode, width, match, upper);
        c.addr = addr;
        c.cur = cur;
        c.prev = prev;
        c.is_last = is_last;
        c.gap = $urandom_range(0, sender_idle_max);
        candidate_queue.push_back(c);
        items_made++;
        wait_drained();
    endtask

    function automatic logic [VALUE_W-1:0] pick_operand();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 255);
            3:       return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Biases the current value toward hits for whichever mode is active
    function automatic candidate_t make_candidate();
        candidate_t c;
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] low;
        m = width_mask();
        c.prev = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF)
                                               : $urandom;
        case ($urandom_range(0, 7))
            0:       low = match_setting;
            1:       low = c.prev + match_setting;
            2:       low = c.prev - match_setting;
            3:       low = c.prev;
            4:       low = upper_setting;
            5:       low = match_setting + $urandom_range(0, 3);
            6:       low = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: low = $urandom;
        endcase
        c.cur = ($urandom & ~m) | (low & m);
        case ($urandom_range(0, 15))
            0:       c.addr = '0;
            1:       c.addr = '1;
            default: c.addr = ADDR_W'($urandom);
        endcase
        c.is_last = ($urandom_range(0, 9) == 0);
        c.gap = $urandom_range(0, sender_idle_max);
        return c;
    endfunction

    initial
    begin
        int phase;
        int count;
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        candidate_t c;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings first: byte equality against zero
        c.addr = '0;
        c.cur = 32'hABCD_EF00;
        c.prev = '0;
        c.is_last = 1'b0;
        c.gap = 0;
        candidate_queue.push_back(c);
        items_made++;
        wait_drained();

        sender_idle_max = 3;
        receiver_idle_max = 3;
        directed_case(CMP_NE, WIDTH_HALF, 32'h1234, 0, '1, 32'hFFFF_1234, 32'hFFFF_FFFF, 1'b0);
        directed_case(CMP_RANGE, WIDTH_WORD, 0, 32'hFFFF_FFFF, 21'h0AAAAA, 32'hFFFF_FFFF, 0,
                      1'b0);
        // lower bound above upper bound keeps nothing
        directed_case(CMP_RANGE, WIDTH_WORD, 10, 5, 21'h155555, 7, 0, 1'b0);
        directed_case(CMP_RANGE, WIDTH_BYTE, 32'h110, 32'h0FF, 21'h000100, 32'h20, 0, 1'b0);
        // narrow increase/decrease must not wrap; word width wraps
        directed_case(CMP_INCBY, WIDTH_BYTE, 32'h20, 0, 21'h000200, 32'h10, 32'hF0, 1'b0);
        directed_case(CMP_INCBY, WIDTH_BYTE, 32'h20, 0, 21'h000201, 32'h30, 32'h10, 1'b0);
        directed_case(CMP_INCBY, WIDTH_WORD, 32'h20, 0, 21'h000202, 32'h10, 32'hFFFF_FFF0, 1'b0);
        directed_case(CMP_DECBY, WIDTH_HALF, 32'h10, 0, 21'h000203, 32'hFFF5, 32'h0005, 1'b0);
        directed_case(CMP_DECBY, WIDTH_HALF, 32'h10, 0, 21'h000204, 32'h1005, 32'h1015, 1'b0);
        directed_case(CMP_DECBY, WIDTH_WORD, 32'h1, 0, 21'h000205, 32'hFFFF_FFFF, 0, 1'b0);
        // width code 3 acts as word
        directed_case(CMP_INC, 2'd3, 0, 0, 21'h000206, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        directed_case(CMP_DEC, WIDTH_BYTE, 0, 0, 21'h000207, 32'hFF00, 32'h01, 1'b0);
        directed_case(CMP_DIFF, WIDTH_WORD, 0, 0, 21'h000208, 0, 0, 1'b0);
        directed_case(CMP_DIFF, WIDTH_BYTE, 0, 0, 21'h000209, 32'h200, 32'h100, 1'b0);
        directed_case(CMP_SAME, WIDTH_HALF, 0, 0, 21'h00020A, 32'h5555_5555, 32'hAAAA_5555,
                      1'b0);
        // unused mode codes keep nothing
        directed_case(4'd9, WIDTH_WORD, 32'h55, 0, 21'h00020B, 32'h55, 32'h55, 1'b0);
        directed_case(4'd15, WIDTH_WORD, 32'h55, 0, 21'h00020C, 32'h55, 32'h55, 1'b1);
        directed_case(CMP_EQ, WIDTH_WORD, 32'hFFFF_FFFF, 0, '1, 32'hFFFF_FFFF, 0, 1'b1);

        phase = 0;
        while (items_made < SCAN_ITEMS)
        begin
            mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
            lo = pick_operand();
            hi = ($urandom_range(0, 2) == 0) ? lo + $urandom_range(0, 300) : pick_operand();
            case ($urandom_range(0, 2))
                0:       sender_idle_max = 0;
                1:       sender_idle_max = 3;
                default: sender_idle_max = 18;
            endcase
            case ($urandom_range(0, 2))
                0:       receiver_idle_max = 0;
                1:       receiver_idle_max = 3;
                default: receiver_idle_max = 18;
            endcase
            count = $urandom_range(10, 50);
            // back-pressure phase: sender streams while the receiver holds off
            if (phase == 4 || phase == 17)
            begin
                sender_idle_max = 0;
                count = 60;
            end
            apply_settings(mode, 2'($urandom_range(0, 3)), lo, hi);
            if (phase == 4 || phase == 17)
                hold_requests++;
            repeat (count)
            begin
                candidate_queue.push_back(make_candidate());
                items_made++;
            end
            wait_drained();
            phase++;
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d candidates over %0d config phases: %0d kept, %0d passes closed.",
                 candidates_sent, phase + 19, kept_total, passes_closed);
        $display("Checked %0d results; input held off for %0d cycles under back-pressure.",
                 results_checked, input_stall_cycles);
        if (error_count == 0 && predicted_verdicts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* memory_value_search_filter_core.f */
hdl/mvsf_pkg.sv
hdl/mvsf_compare.sv
hdl/memory_value_search_filter_core.sv
tb/memory_value_search_filter_core_tb.sv
